/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers, with and without reset qualification.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion disabled while reset is asserted
`define BTRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion active at every edge, reset included
`define BTRC_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/btrc_pkg.sv */
// ----------------------------------------------------------------------------
// btrc_pkg
// Types, codes and the CRC-16 byte update shared by the telegram receiver.
// ----------------------------------------------------------------------------
package btrc_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_CRC_ENABLE   = 3'd0;
    localparam logic [2:0] CFG_STD_PATTERN  = 3'd1;
    localparam logic [2:0] CFG_EXT_PATTERN  = 3'd2;
    localparam logic [2:0] CFG_POLL_PATTERN = 3'd3;
    localparam logic [2:0] CFG_MATCH_MASK   = 3'd4;
    localparam logic [2:0] CFG_STATE_BITS   = 3'd5;
    localparam logic [2:0] CFG_SYSSTATE_BITS = 3'd6;

    localparam logic [7:0] MATCH_MASK_RESET = 8'hFF;

    // event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_OK       = 3'd1;
    localparam logic [2:0] EV_BAD      = 3'd2;
    localparam logic [2:0] EV_STATE    = 3'd3;
    localparam logic [2:0] EV_SYSSTATE = 3'd4;

    // telegram size limits
    localparam logic [8:0] STD_MIN  = 9'd8;
    localparam logic [8:0] STD_MAX  = 9'd23;
    localparam logic [8:0] EXT_MIN  = 9'd9;
    localparam logic [8:0] EXT_MAX  = 9'd263;
    localparam logic [8:0] POLL_MIN = 9'd6;
    localparam logic [8:0] POLL_MAX = 9'd6;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic       crc_enable;
        logic [7:0] standard_pattern;
        logic [7:0] extended_pattern;
        logic [7:0] poll_pattern;
        logic [7:0] match_mask;
        logic [7:0] state_bits;
        logic [7:0] system_state_bits;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{crc_enable: 1'b0, standard_pattern: 8'h00,
                                   extended_pattern: 8'h00, poll_pattern: 8'h00,
                                   match_mask: MATCH_MASK_RESET, state_bits: 8'h00,
                                   system_state_bits: 8'h00};

    typedef struct packed {
        logic       start;
        logic [8:0] min_size;
        logic [8:0] max_size;
        logic       state_ind;
        logic       sys_state_ind;
    } t_class;

    // first member in the top bits, event_res in the lowest bits
    typedef struct packed {
        logic [7:0] store_data;
        logic [8:0] store_index;
        logic       store_valid;
        logic [7:0] status_byte;
        logic [9:0] frame_len;
        logic [2:0] event_res;
    } t_result;

    localparam int RES_W      = $bits(t_result);
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* rtl/core/btrc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// btrc_cfg_regs
// Configuration register bank written through the index/data write channel.
// ----------------------------------------------------------------------------
module btrc_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [2:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output btrc_pkg::t_cfg    o_cfg
);

    btrc_pkg::t_cfg r_cfg;
    btrc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                btrc_pkg::CFG_CRC_ENABLE:    n_cfg.crc_enable        = i_cfg_data[0];
                btrc_pkg::CFG_STD_PATTERN:   n_cfg.standard_pattern  = i_cfg_data;
                btrc_pkg::CFG_EXT_PATTERN:   n_cfg.extended_pattern  = i_cfg_data;
                btrc_pkg::CFG_POLL_PATTERN:  n_cfg.poll_pattern      = i_cfg_data;
                btrc_pkg::CFG_MATCH_MASK:    n_cfg.match_mask        = i_cfg_data;
                btrc_pkg::CFG_STATE_BITS:    n_cfg.state_bits        = i_cfg_data;
                btrc_pkg::CFG_SYSSTATE_BITS: n_cfg.system_state_bits = i_cfg_data;
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= btrc_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/btrc_classify.sv */
// ----------------------------------------------------------------------------
// btrc_classify
// Classifies a byte seen while idle: telegram start type or indication.
// ----------------------------------------------------------------------------
module btrc_classify (
    input  logic [7:0]        i_byte,
    input  btrc_pkg::t_cfg    i_cfg,
    output btrc_pkg::t_class  o_cls
);

    logic [7:0] w_masked;
    logic       w_std;
    logic       w_ext;
    logic       w_poll;

    assign w_masked = i_byte & i_cfg.match_mask;
    assign w_std    = w_masked == (i_cfg.standard_pattern & i_cfg.match_mask);
    assign w_ext    = w_masked == (i_cfg.extended_pattern & i_cfg.match_mask);
    assign w_poll   = w_masked == (i_cfg.poll_pattern & i_cfg.match_mask);

    always_comb begin
        o_cls = '0;
        if (w_std) begin
            o_cls.start    = 1'b1;
            o_cls.min_size = btrc_pkg::STD_MIN;
            o_cls.max_size = btrc_pkg::STD_MAX;
        end else if (w_ext) begin
            o_cls.start    = 1'b1;
            o_cls.min_size = btrc_pkg::EXT_MIN;
            o_cls.max_size = btrc_pkg::EXT_MAX;
        end else if (w_poll) begin
            o_cls.start    = 1'b1;
            o_cls.min_size = btrc_pkg::POLL_MIN;
            o_cls.max_size = btrc_pkg::POLL_MAX;
        end else if ((i_byte & i_cfg.state_bits) != 8'h00) begin
            o_cls.state_ind = 1'b1;
        end else if ((i_byte & i_cfg.system_state_bits) != 8'h00) begin
            o_cls.sys_state_ind = 1'b1;
        end
    end

endmodule

/* rtl/core/btrc_rx_engine.sv */
// ----------------------------------------------------------------------------
// btrc_rx_engine
// Telegram state, byte counter, delayed CRC and completion checks.
// ----------------------------------------------------------------------------
module btrc_rx_engine #(
    parameter int BUF_BYTES = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic               i_kind,
    input  logic [7:0]         i_byte,
    input  btrc_pkg::t_cfg     i_cfg,
    input  btrc_pkg::t_class   i_cls,
    output btrc_pkg::t_result  o_res
);

    localparam int CW    = $clog2(BUF_BYTES + 1);
    localparam int CMP_W = (CW > 10) ? CW : 10;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_RECV = 2'd1;
    localparam logic [1:0] MODE_DONE = 2'd2;

    logic [1:0]       r_mode,    n_mode;
    logic [CW-1:0]    r_count,   n_count;
    logic [8:0]       r_min,     n_min;
    logic [8:0]       r_max,     n_max;
    logic [15:0]      r_crc,     n_crc;
    logic             r_match,   n_match;
    logic [7:0]       r_recent0, n_recent0;
    logic [7:0]       r_recent1, n_recent1;

    logic [CMP_W-1:0] w_count_x;
    logic [CMP_W-1:0] w_next_x;
    logic [CMP_W-1:0] w_min_x;
    logic [CMP_W-1:0] w_max_x;
    logic [CMP_W-1:0] w_fin_size;
    logic             w_fin;
    logic             w_fin_match;
    logic             w_bad;
    logic [15:0]      w_crc_upd;

    assign w_count_x = CMP_W'(r_count);
    assign w_next_x  = w_count_x + CMP_W'(1);
    assign w_min_x   = CMP_W'(r_min);
    assign w_max_x   = CMP_W'(r_max);
    assign w_crc_upd = btrc_pkg::crc16_byte(r_crc, r_recent1);

    always_comb begin
        n_mode      = r_mode;
        n_count     = r_count;
        n_min       = r_min;
        n_max       = r_max;
        n_crc       = r_crc;
        n_match     = r_match;
        n_recent0   = r_recent0;
        n_recent1   = r_recent1;
        o_res       = '0;
        w_fin       = 1'b0;
        w_fin_size  = '0;
        w_fin_match = r_match;
        w_bad       = 1'b0;

        if (i_kind) begin
            if (r_mode == MODE_RECV) begin
                w_fin      = 1'b1;
                w_fin_size = w_count_x;
            end
            n_mode = MODE_IDLE;
        end else if (r_mode == MODE_IDLE) begin
            if (i_cls.start) begin
                n_mode            = MODE_RECV;
                n_count           = CW'(1);
                n_min             = i_cls.min_size;
                n_max             = i_cls.max_size;
                n_crc             = btrc_pkg::CRC_INIT;
                n_match           = 1'b0;
                n_recent0         = i_byte;
                n_recent1         = 8'h00;
                o_res.store_valid = 1'b1;
                o_res.store_data  = i_byte;
            end else if (i_cls.state_ind) begin
                o_res.event_res   = btrc_pkg::EV_STATE;
                o_res.status_byte = i_byte;
            end else if (i_cls.sys_state_ind) begin
                o_res.event_res   = btrc_pkg::EV_SYSSTATE;
                o_res.status_byte = i_byte;
            end
        end else begin
            n_mode = MODE_RECV;
            if (r_count < CW'(BUF_BYTES)) begin
                n_count           = r_count + CW'(1);
                n_recent1         = r_recent0;
                n_recent0         = i_byte;
                o_res.store_valid = 1'b1;
                o_res.store_index = w_count_x[8:0];
                o_res.store_data  = i_byte;
                if (i_cfg.crc_enable) begin
                    if (w_next_x > CMP_W'(2)) begin
                        n_crc = w_crc_upd;
                    end
                    if (w_next_x >= w_min_x + CMP_W'(2)) begin
                        n_match = ({r_recent0, i_byte} == n_crc);
                        if (n_match) begin
                            w_fin       = 1'b1;
                            w_fin_size  = w_next_x - CMP_W'(2);
                            w_fin_match = 1'b1;
                            n_mode      = MODE_DONE;
                        end
                    end
                end
            end
        end

        if (w_fin) begin
            w_bad = (w_fin_size < w_min_x) || (w_fin_size > w_max_x) ||
                    (i_cfg.crc_enable && !w_fin_match);
            o_res.frame_len = w_fin_size[9:0];
            o_res.event_res = w_bad ? btrc_pkg::EV_BAD : btrc_pkg::EV_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_count   <= '0;
            r_min     <= '0;
            r_max     <= '0;
            r_crc     <= btrc_pkg::CRC_INIT;
            r_match   <= 1'b0;
            r_recent0 <= '0;
            r_recent1 <= '0;
        end else if (i_go) begin
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_min     <= n_min;
            r_max     <= n_max;
            r_crc     <= n_crc;
            r_match   <= n_match;
            r_recent0 <= n_recent0;
            r_recent1 <= n_recent1;
        end
    end

endmodule

/* rtl/core/bus_telegram_receiver_crc_core.sv */
// ----------------------------------------------------------------------------
// bus_telegram_receiver_crc_core
// Bus telegram receiver with start classification and CRC-16-CCITT check.
// ----------------------------------------------------------------------------
// Accepts one received byte or gap tick per clock unless the output stalls,
// and returns exactly one result per transfer through the input register,
// then the result register. Throughput is one transfer per cycle when not
// stalled, set by the combinational update of the telegram state and the
// byte-wide CRC step. The configuration channel is always ready; the user
// must ensure it is written while no transfer is in flight (unchecked).
module bus_telegram_receiver_crc_core #(
    parameter int BUF_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] event_res, [12:3] frame_len, [20:13] status_byte,
    // [21] store_valid, [30:22] store_index, [38:31] store_data
    output logic [btrc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    btrc_pkg::t_cfg    w_cfg;
    btrc_pkg::t_class  w_cls;
    btrc_pkg::t_result w_res;

    logic              r_in_valid;
    logic              r_in_kind;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    btrc_pkg::t_result r_out_res;
    logic              w_adv;
    logic              w_go;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_go          = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign o_cfg_ready   = 1'b1;

    btrc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    btrc_classify u_cls (
        .i_byte (r_in_byte),
        .i_cfg  (w_cfg),
        .o_cls  (w_cls)
    );

    btrc_rx_engine #(
        .BUF_BYTES (BUF_BYTES)
    ) u_eng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_kind  (r_in_kind),
        .i_byte  (r_in_byte),
        .i_cfg   (w_cfg),
        .i_cls   (w_cls),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = btrc_pkg::OUT_DATA_W'(r_out_res);

endmodule

/* rtl/core/btrc_checker.sv */
// ----------------------------------------------------------------------------
// btrc_checker
// Port-level checks on result transfers, bound to the receiver top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btrc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [btrc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    btrc_pkg::t_result                  w_res;
    logic                               w_tgm;
    logic                               w_ind;
    logic                               w_stall;
    logic [btrc_pkg::OUT_DATA_W:0]      w_beat;
    logic                               w_tgm_ok;
    logic                               w_ind_ok;
    logic                               w_no_store;
    logic                               w_store_zero;

    assign w_res = btrc_pkg::t_result'(m_axis_tdata[btrc_pkg::RES_W-1:0]);
    assign w_tgm = m_axis_tvalid &&
                   ((w_res.event_res == btrc_pkg::EV_OK) ||
                    (w_res.event_res == btrc_pkg::EV_BAD));
    assign w_ind = m_axis_tvalid &&
                   ((w_res.event_res == btrc_pkg::EV_STATE) ||
                    (w_res.event_res == btrc_pkg::EV_SYSSTATE));
    assign w_stall      = m_axis_tvalid && !m_axis_tready;
    assign w_beat       = {m_axis_tvalid, m_axis_tdata};
    assign w_tgm_ok     = (w_res.frame_len != 10'd0) && (w_res.status_byte == 8'd0);
    assign w_ind_ok     = !w_res.store_valid && (w_res.status_byte != 8'd0) &&
                          (w_res.frame_len == 10'd0);
    assign w_no_store   = m_axis_tvalid && !w_res.store_valid;
    assign w_store_zero = (w_res.store_index == 9'd0) && (w_res.store_data == 8'd0);

    `BTRC_ASSERT_NR(a_rst_clears_out, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid after reset")
    `BTRC_ASSERT(a_out_hold, i_clk, i_rst_n, w_stall |=> $stable(w_beat), "result changed")
    `BTRC_ASSERT(a_tgm_size, i_clk, i_rst_n, w_tgm |-> w_tgm_ok, "telegram event fields")
    `BTRC_ASSERT(a_ind_fields, i_clk, i_rst_n, w_ind |-> w_ind_ok, "indication fields")
    `BTRC_ASSERT(a_nostore_zero, i_clk, i_rst_n, w_no_store |-> w_store_zero, "store fields set")

endmodule

bind bus_telegram_receiver_crc_core btrc_checker u_btrc_checker (.*);
